[design/aarm_pkg.sv]
// Shared types and constants for the axis-align rotation matrix unit.
// No dependencies; every design file imports this package.
package aarm_pkg;

    // Bus and register layout
    localparam int            DATA_W      = 32;
    localparam int            ADDR_W      = 3;
    localparam int            EPS_W       = 14;
    localparam logic [EPS_W-1:0] EPS_RESET = 14'd2;
    localparam logic [0:0]    REG_EPSILON = 1'b0;

    // Normalized magnitude width (always below 2^31 after scaling)
    localparam int MAG_W = 31;

    // case_taken codes
    localparam logic [1:0] CASE_GENERAL  = 2'd0;
    localparam logic [1:0] CASE_ALIGNED  = 2'd1;
    localparam logic [1:0] CASE_OPPOSITE = 2'd2;

    typedef struct packed {
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic [1:0]         case_taken;
        logic               degenerate;
    } out_t;

    // Front end result carried alongside the sum of squares
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  deg;
    } front_side_t;

endpackage

[design/aarm_front.sv]
// Front end: sign split, max, scale normalization, squares and sum of squares.
// Five register stages with bubble-collapsing flow control. Uses aarm_pkg.
module aarm_front
    import aarm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_sum,
    output front_side_t out_side
);

    localparam int NS = 5;

    logic adv [NS+1];

    // stage A: magnitudes and max
    logic              va_reg;
    logic [2:0][31:0]  mag_a_reg;
    logic [2:0]        neg_a_reg;
    logic [31:0]       mx_a_reg;
    // stage B: shift decision
    logic              vb_reg;
    logic [2:0][31:0]  mag_b_reg;
    logic [2:0]        neg_b_reg;
    logic              right_b_reg;
    logic [4:0]        sh_b_reg;
    logic              deg_b_reg;
    // stage C: scaled magnitudes
    logic              vc_reg;
    front_side_t       side_c_reg;
    // stage D: squares
    logic              vd_reg;
    front_side_t       side_d_reg;
    logic [2:0][61:0]  sq_d_reg;
    // stage E: sum
    logic              ve_reg;
    front_side_t       side_e_reg;
    logic [63:0]       sum_e_reg;

    logic [2:0][31:0]  mag_a_next;
    logic [31:0]       mx_a_next;
    logic [2:0][MAG_W-1:0] mag_c_next;

    function automatic logic [4:0] left_shift(input logic [31:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < 30; i++) begin
            if (v[i]) begin
                pos = 5'(i);
            end
        end
        return 5'd29 - pos;
    endfunction

    assign adv[NS] = out_ready;
    assign adv[4]  = !ve_reg | adv[5];
    assign adv[3]  = !vd_reg | adv[4];
    assign adv[2]  = !vc_reg | adv[3];
    assign adv[1]  = !vb_reg | adv[2];
    assign adv[0]  = !va_reg | adv[1];
    assign in_ready = adv[0];

    always_comb begin
        mag_a_next[0] = in_data.axis_x[31] ? (32'd0 - in_data.axis_x) : in_data.axis_x;
        mag_a_next[1] = in_data.axis_y[31] ? (32'd0 - in_data.axis_y) : in_data.axis_y;
        mag_a_next[2] = in_data.axis_z[31] ? (32'd0 - in_data.axis_z) : in_data.axis_z;
        mx_a_next = mag_a_next[0];
        if (mag_a_next[1] > mx_a_next) begin
            mx_a_next = mag_a_next[1];
        end
        if (mag_a_next[2] > mx_a_next) begin
            mx_a_next = mag_a_next[2];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (right_b_reg) begin
                mag_c_next[i] = MAG_W'(mag_b_reg[i] >> 1);
            end else begin
                mag_c_next[i] = MAG_W'(mag_b_reg[i] << sh_b_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (adv[0]) va_reg <= in_valid;
            if (adv[1]) vb_reg <= va_reg;
            if (adv[2]) vc_reg <= vb_reg;
            if (adv[3]) vd_reg <= vc_reg;
            if (adv[4]) ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            mag_a_reg <= mag_a_next;
            neg_a_reg <= {in_data.axis_z[31], in_data.axis_y[31], in_data.axis_x[31]};
            mx_a_reg  <= mx_a_next;
        end
        if (adv[1]) begin
            mag_b_reg   <= mag_a_reg;
            neg_b_reg   <= neg_a_reg;
            right_b_reg <= mx_a_reg[31] | mx_a_reg[30];
            sh_b_reg    <= left_shift(mx_a_reg);
            deg_b_reg   <= (mx_a_reg == 32'd0);
        end
        if (adv[2]) begin
            side_c_reg.mag <= mag_c_next;
            side_c_reg.neg <= neg_b_reg;
            side_c_reg.deg <= deg_b_reg;
        end
        if (adv[3]) begin
            side_d_reg <= side_c_reg;
            for (int i = 0; i < 3; i++) begin
                sq_d_reg[i] <= side_c_reg.mag[i] * side_c_reg.mag[i];
            end
        end
        if (adv[4]) begin
            side_e_reg <= side_d_reg;
            sum_e_reg  <= 64'(sq_d_reg[0]) + 64'(sq_d_reg[1]) + 64'(sq_d_reg[2]);
        end
    end

    assign out_valid = ve_reg;
    assign out_sum   = sum_e_reg;
    assign out_side  = side_e_reg;

endmodule

[design/aarm_isqrt.sv]
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Carries an opaque side vector. Uses aarm_pkg only for house conventions.
module aarm_isqrt
    import aarm_pkg::*;
#(
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [63:0]   in_sum,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_root,
    output logic [SW-1:0] out_side
);

    localparam int NS = 32;

    logic          v_reg    [NS];
    logic [63:0]   s_reg    [NS];
    logic [63:0]   r_reg    [NS];
    logic [SW-1:0] side_reg [NS];
    logic          adv      [NS+1];

    assign adv[NS]   = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_root  = r_reg[NS-1][31:0];
    assign out_side  = side_reg[NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [63:0] B = 64'd1 << (2 * (NS - 1 - k));
        logic          v_in;
        logic [63:0]   s_in;
        logic [63:0]   r_in;
        logic [SW-1:0] side_in;
        logic [63:0]   rb;
        logic [63:0]   s_d;
        logic [63:0]   r_d;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign s_in    = in_sum;
            assign r_in    = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign s_in    = s_reg[k-1];
            assign r_in    = r_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign adv[k] = !v_reg[k] | adv[k+1];

        always_comb begin
            rb = r_in + B;
            if (s_in >= rb) begin
                s_d = s_in - rb;
                r_d = (r_in >> 1) + B;
            end else begin
                s_d = s_in;
                r_d = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                s_reg[k]    <= s_d;
                r_reg[k]    <= r_d;
                side_reg[k] <= side_in;
            end
        end
    end

endmodule

[design/aarm_div.sv]
// Pipelined restoring divider: a bias-add stage, then one quotient bit per stage.
// Several numerators share one divisor; carries an opaque side vector.
module aarm_div
    import aarm_pkg::*;
#(
    parameter int NW    = 32,
    parameter int DW    = 16,
    parameter int QW    = 8,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [LANES-1:0][NW-1:0]    in_num,
    input  logic [NW-1:0]               in_add,
    input  logic [DW-1:0]               in_den,
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [LANES-1:0][QW-1:0]    out_quo,
    output logic [SW-1:0]               out_side
);

    localparam int RW = (NW > DW + QW - 1) ? NW : DW + QW - 1;
    localparam int NS = QW + 1;

    logic                     v_reg    [NS];
    logic [LANES-1:0][RW-1:0] rem_reg  [NS];
    logic [LANES-1:0][QW-1:0] quo_reg  [NS];
    logic [DW-1:0]            den_reg  [NS];
    logic [SW-1:0]            side_reg [NS];
    logic                     adv      [NS+1];

    assign adv[NS]   = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

    // stage 0: rounding bias
    assign adv[0] = !v_reg[0] | adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv[0]) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= RW'(in_num[l]) + RW'(in_add);
            end
            quo_reg[0]  <= '0;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        localparam int BIT = QW - k;
        logic [RW-1:0]            trial;
        logic [LANES-1:0][RW-1:0] rem_d;
        logic [LANES-1:0][QW-1:0] quo_d;

        assign adv[k] = !v_reg[k] | adv[k+1];

        always_comb begin
            trial = RW'(den_reg[k-1]) << BIT;
            for (int l = 0; l < LANES; l++) begin
                if (rem_reg[k-1][l] >= trial) begin
                    rem_d[l] = rem_reg[k-1][l] - trial;
                    quo_d[l] = quo_reg[k-1][l] | (QW'(1) << BIT);
                end else begin
                    rem_d[l] = rem_reg[k-1][l];
                    quo_d[l] = quo_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_d;
                quo_reg[k]  <= quo_d;
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

endmodule

[design/axis_align_rotation_matrix_unit.sv]
// Top level: rotation matrix taking +Y onto a Q16.16 direction, Q-format output.
// Depends on aarm_pkg, aarm_front, aarm_isqrt and aarm_div.
//
//   channel   ports                          direction   payload
//   s_        s_valid, s_ready, s_data       in          in_t  (axis_x/y/z, Q16.16)
//   m_        m_valid, m_ready, m_data       out         out_t (m00..m22, case, degenerate)
//   apb       psel, penable, pwrite, paddr,  in/out      epsilon at byte address 0
//             pwdata, prdata, pready
//
// One request per cycle sustained while m_ready is held high.
// The pipeline runs through the 32-stage square root and the two pipelined dividers
// (OUT_FRAC_BITS+1 and 2*OUT_FRAC_BITS+1 quotient bits, each plus a bias stage).
// Reset clears every stage valid bit and loads epsilon with 2.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up and a stalled m_ready holds the output while earlier stages fill.
module axis_align_rotation_matrix_unit
    import aarm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input requests
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    // result requests
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int F    = OUT_FRAC_BITS;
    localparam int NW1  = 32 + F;        // n numerator: mag * 2^F + L/2
    localparam int QW1  = F + 1;         // |n| <= 2^F
    localparam int NW2  = 2 * F + 2;     // product magnitude + den/2
    localparam int DW2  = F + 2;         // den in [0, 2^(F+1)]
    localparam int QW2  = 2 * F + 1;
    localparam int PW   = 2 * F + 1;     // product magnitude <= 2^(2F)
    localparam int PFW  = 2 * F + 2;
    localparam int NSW  = F + 2;         // signed normalized component
    localparam int WW   = F + 3;         // room for 1 +/- c
    localparam int SUMW = 2 * F + 3;
    localparam int CW   = (F + 2 > EPS_W) ? F + 2 : EPS_W;
    localparam int FSW  = $bits(front_side_t);

    localparam logic signed [WW-1:0]   ONE_W  = WW'(1 << F);
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(32767);
    localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(-32768);
    // 1.0 and -1.0 after 16-bit saturation
    localparam logic signed [15:0] ONE_Q     = (F > 14) ? 16'sh7fff : 16'(1 << F);
    localparam logic signed [15:0] NEG_ONE_Q = (F > 14) ? 16'sh8000 : 16'(-(1 << F));

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } d1_side_t;

    typedef struct packed {
        logic signed [NSW-1:0] c;
        logic signed [NSW-1:0] nx;
        logic signed [NSW-1:0] nz;
        logic                  sxz;
        logic [1:0]            ct;
        logic                  deg;
    } d2_side_t;

    function automatic logic signed [15:0] sat16(input logic signed [SUMW-1:0] v);
        if (v > SAT_HI) begin
            return 16'sh7fff;
        end else if (v < SAT_LO) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // ---------------------------------------------------------------- config
    logic [EPS_W-1:0] eps_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_EPSILON) begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1:2] == REG_EPSILON) ? DATA_W'(eps_reg) : '0;

    // ---------------------------------------------------------------- front end
    logic        fe_valid, fe_ready;
    logic [63:0] fe_sum;
    front_side_t fe_side;

    aarm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_sum   (fe_sum),
        .out_side  (fe_side)
    );

    // ---------------------------------------------------------------- length
    logic           sq_valid, sq_ready;
    logic [31:0]    sq_root;
    logic [FSW-1:0] sq_side_vec;
    front_side_t    sq_side;

    aarm_isqrt #(.SW(FSW)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_sum    (fe_sum),
        .in_side   (fe_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_root  (sq_root),
        .out_side  (sq_side_vec)
    );

    assign sq_side = sq_side_vec;

    // ---------------------------------------------------------------- normalize
    logic [2:0][NW1-1:0] d1_num;
    d1_side_t            d1_side_in;
    logic                d1_valid, d1_ready;
    logic [2:0][QW1-1:0] d1_quo;
    logic [3:0]          d1_side_vec;
    d1_side_t            d1_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1_num[i] = {1'b0, sq_side.mag[i], {F{1'b0}}};
        end
        d1_side_in.neg = sq_side.neg;
        d1_side_in.deg = sq_side.deg;
    end

    aarm_div #(.NW(NW1), .DW(32), .QW(QW1), .LANES(3), .SW(4)) u_div_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_num    (d1_num),
        .in_add    (NW1'(sq_root >> 1)),
        .in_den    (sq_root),
        .in_side   (d1_side_in),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (d1_quo),
        .out_side  (d1_side_vec)
    );

    assign d1_side = d1_side_vec;

    // ---------------------------------------------------------------- case + products
    // c = ny, den = 1 + c. Aligned and opposite tests against epsilon, products
    // of component magnitudes for the three quotient terms.
    logic signed [NSW-1:0] c_w, nx_w, nz_w;
    logic signed [WW-1:0]  den_w, omc_w;
    logic [CW-1:0]         eps_ext;
    logic                  aligned, opposite;
    logic [1:0]            ct_w;
    logic [PFW-1:0]        pzz_full, pxz_full, pxx_full;

    logic                  p_valid_reg;
    logic                  p_adv;
    logic [PW-1:0]         p_zz_reg, p_xz_reg, p_xx_reg;
    logic [DW2-1:0]        p_den_reg;
    d2_side_t              p_side_reg;
    logic                  d2_ready;

    always_comb begin
        c_w  = d1_side.neg[1] ? -$signed({1'b0, d1_quo[1]}) : $signed({1'b0, d1_quo[1]});
        nx_w = d1_side.neg[0] ? -$signed({1'b0, d1_quo[0]}) : $signed({1'b0, d1_quo[0]});
        nz_w = d1_side.neg[2] ? -$signed({1'b0, d1_quo[2]}) : $signed({1'b0, d1_quo[2]});
        den_w   = ONE_W + WW'(c_w);
        omc_w   = ONE_W - WW'(c_w);
        eps_ext = CW'(eps_reg);
        aligned  = CW'(omc_w[F+1:0]) < eps_ext;
        opposite = (CW'(den_w[F+1:0]) < eps_ext) || (den_w == '0);
        priority if (d1_side.deg) begin
            ct_w = CASE_ALIGNED;
        end else if (aligned) begin
            ct_w = CASE_ALIGNED;
        end else if (opposite) begin
            ct_w = CASE_OPPOSITE;
        end else begin
            ct_w = CASE_GENERAL;
        end
        pzz_full = d1_quo[2] * d1_quo[2];
        pxz_full = d1_quo[0] * d1_quo[2];
        pxx_full = d1_quo[0] * d1_quo[0];
    end

    assign p_adv    = !p_valid_reg | d2_ready;
    assign d1_ready = p_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_adv) begin
            p_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_adv) begin
            p_zz_reg       <= pzz_full[PW-1:0];
            p_xz_reg       <= pxz_full[PW-1:0];
            p_xx_reg       <= pxx_full[PW-1:0];
            p_den_reg      <= den_w[F+1:0];
            p_side_reg.c   <= c_w;
            p_side_reg.nx  <= nx_w;
            p_side_reg.nz  <= nz_w;
            p_side_reg.sxz <= d1_side.neg[0] ^ d1_side.neg[2];
            p_side_reg.ct  <= ct_w;
            p_side_reg.deg <= d1_side.deg;
        end
    end

    // ---------------------------------------------------------------- rounded quotients
    // lane 0: nz^2/den, lane 1: |nx*nz|/den, lane 2: nx^2/den
    logic [2:0][NW2-1:0]         d2_num;
    logic                        d2_valid;
    logic                        o_adv;
    logic [2:0][QW2-1:0]         d2_quo;
    logic [$bits(d2_side_t)-1:0] d2_side_vec;
    d2_side_t                    d2_side;

    assign d2_num[0] = NW2'(p_zz_reg);
    assign d2_num[1] = NW2'(p_xz_reg);
    assign d2_num[2] = NW2'(p_xx_reg);

    aarm_div #(.NW(NW2), .DW(DW2), .QW(QW2), .LANES(3), .SW($bits(d2_side_t))) u_div_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_valid_reg),
        .in_ready  (d2_ready),
        .in_num    (d2_num),
        .in_add    (NW2'(p_den_reg >> 1)),
        .in_den    (p_den_reg),
        .in_side   (p_side_reg),
        .out_valid (d2_valid),
        .out_ready (o_adv),
        .out_quo   (d2_quo),
        .out_side  (d2_side_vec)
    );

    assign d2_side = d2_side_vec;

    // ---------------------------------------------------------------- assemble
    logic signed [SUMW-1:0] a00, a22, cross_w;
    out_t                   o_next;
    logic                   m_valid_reg;
    out_t                   m_data_reg;

    always_comb begin
        a00   = SUMW'(d2_side.c) + $signed(SUMW'(d2_quo[0]));
        a22   = SUMW'(d2_side.c) + $signed(SUMW'(d2_quo[2]));
        // cross_w = -round(nx*nz/den)
        cross_w = d2_side.sxz ? $signed(SUMW'(d2_quo[1])) : -$signed(SUMW'(d2_quo[1]));
        o_next = '0;
        o_next.case_taken = d2_side.ct;
        o_next.degenerate = d2_side.deg;
        unique case (d2_side.ct)
            CASE_GENERAL: begin
                o_next.m00 = sat16(a00);
                o_next.m01 = sat16(SUMW'(d2_side.nx));
                o_next.m02 = sat16(cross_w);
                o_next.m10 = sat16(-SUMW'(d2_side.nx));
                o_next.m11 = sat16(SUMW'(d2_side.c));
                o_next.m12 = sat16(-SUMW'(d2_side.nz));
                o_next.m20 = sat16(cross_w);
                o_next.m21 = sat16(SUMW'(d2_side.nz));
                o_next.m22 = sat16(a22);
            end
            CASE_OPPOSITE: begin
                o_next.m00 = ONE_Q;
                o_next.m11 = NEG_ONE_Q;
                o_next.m22 = NEG_ONE_Q;
            end
            default: begin
                o_next.m00 = ONE_Q;
                o_next.m11 = ONE_Q;
                o_next.m22 = ONE_Q;
            end
        endcase
    end

    assign o_adv = !m_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_adv) begin
            m_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_adv) begin
            m_data_reg <= o_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------- checks
    // input side only stalls when a finished result is waiting
    a_stall_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output register");

    // zero vector always reports identity
    a_degenerate_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.case_taken == CASE_ALIGNED && m_data.m00 == ONE_Q && m_data.m12 == 16'sd0)
        else $error("degenerate result is not identity");

    // special cases are diagonal
    a_special_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.case_taken != CASE_GENERAL |->
            m_data.m10 == 16'sd0 && m_data.m21 == 16'sd0 && m_data.m02 == 16'sd0)
        else $error("special-case matrix has off-diagonal terms");

endmodule
